FILE: rtl/tdwt_pkg.sv
`timescale 1ns / 1ps
package tdwt_pkg;

  localparam int unsigned CNT_W     = 9;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned TMO_W     = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_NEXT   = 3'd0,
    OP_RESET  = 3'd1,
    OP_STATUS = 3'd2,
    OP_ALIVE  = 3'd3,
    OP_DONE   = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TASK_COUNT = 1'b0,
    REG_TIMEOUT    = 1'b1
  } reg_e;

endpackage

FILE: rtl/tdwt_if.sv
`timescale 1ns / 1ps
interface tdwt_req_if #(
  parameter int unsigned TW = 32
);
  logic                        valid;
  logic                        ready;
  logic [tdwt_pkg::OP_W-1:0]   operation;
  logic [tdwt_pkg::CNT_W-1:0]  task_id;
  logic [TW-1:0]               now_time;

  modport source (output valid, operation, task_id, now_time, input ready);
  modport sink   (input valid, operation, task_id, now_time, output ready);
endinterface

interface tdwt_rsp_if #(
  parameter int unsigned TW = 32
);
  logic                        valid;
  logic                        ready;
  logic [tdwt_pkg::CNT_W-1:0]  granted_task;
  logic                        status;
  logic [tdwt_pkg::CNT_W-1:0]  next_candidate;
  logic [tdwt_pkg::CNT_W-1:0]  completed_count;
  logic [tdwt_pkg::CNT_W-1:0]  remaining_at_cleanup;
  logic [TW-1:0]               oldest_start;
  logic [TW-1:0]               last_issued;
  logic                        in_cleanup;

  modport source (output valid, granted_task, status, next_candidate, completed_count,
                  remaining_at_cleanup, oldest_start, last_issued, in_cleanup,
                  input ready);
  modport sink   (input valid, granted_task, status, next_candidate, completed_count,
                  remaining_at_cleanup, oldest_start, last_issued, in_cleanup,
                  output ready);
endinterface

FILE: rtl/tdwt_stamp_ram.sv
`timescale 1ns / 1ps
module tdwt_stamp_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/task_dispatcher_with_timeout_reissue.sv
`timescale 1ns / 1ps
// channel   dir  handshake            payload
// req_i     in   valid/ready          operation, task_id, now_time
// rsp_o     out  valid/ready          granted_task, status, next_candidate, completed_count,
//                                     remaining_at_cleanup, oldest_start, last_issued,
//                                     in_cleanup
// cfg       in   cfg_we_i (no ready)  cfg_idx_i, cfg_data_i
//
// One word at a time. status or a bad id goes straight to the result register; next
// passes ISSUE, alive/done READ and CHECK; a next that ends the first stage, a reissue,
// or an alive/done on the current candidate in cleanup adds a scan of the table entries.
// Reset op and a task_count write first zero task_count table entries, one per cycle.
// The stamp table has one read port, which sets the scan length.
// The result register lets the next word in while rsp_o is stalled.
module task_dispatcher_with_timeout_reissue #(
  parameter int unsigned MAX_TASKS  = 256,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  tdwt_req_if.sink                          req_i,
  tdwt_rsp_if.source                        rsp_o,
  input  logic                              cfg_we_i,
  input  logic [tdwt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tdwt_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned CNT_W   = tdwt_pkg::CNT_W;
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
  localparam int unsigned DEPTH   = (MAX_TASKS < CNT_MAX) ? MAX_TASKS : CNT_MAX;
  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TW      = TIME_WIDTH;
  localparam int unsigned DW      = (TW > tdwt_pkg::TMO_W) ? TW : tdwt_pkg::TMO_W;
  localparam logic [TW-1:0] T_ALL   = '1;
  localparam logic [TW-1:0] T_CLAMP = T_ALL - 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_ISSUE,
    S_READ,
    S_CHECK,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                     state_q;
  tdwt_pkg::cnt_t             tcount_q;
  logic [tdwt_pkg::TMO_W-1:0] timeout_q;
  logic                       cleanup_q;
  tdwt_pkg::cnt_t             next_q;
  tdwt_pkg::cnt_t             done_q;
  tdwt_pkg::cnt_t             left_q;
  logic [TW-1:0]              cand_q;
  logic [TW-1:0]              last_q;
  logic [tdwt_pkg::OP_W-1:0]  op_q;
  tdwt_pkg::cnt_t             id_q;
  logic [TW-1:0]              now_q;
  tdwt_pkg::cnt_t             granted_q;
  logic                       status_q;
  tdwt_pkg::cnt_t             idx_q;
  tdwt_pkg::cnt_t             open_q;
  logic                       pend_q;
  logic                       post_q;
  logic                       setleft_q;

  logic                       rsp_valid_q;
  tdwt_pkg::cnt_t             rsp_granted_q;
  logic                       rsp_status_q;
  tdwt_pkg::cnt_t             rsp_next_q;
  tdwt_pkg::cnt_t             rsp_done_q;
  tdwt_pkg::cnt_t             rsp_left_q;
  logic [TW-1:0]              rsp_cand_q;
  logic [TW-1:0]              rsp_last_q;
  logic                       rsp_cleanup_q;

  logic                       acc;
  logic [TW-1:0]              now_in;
  logic                       id_ok;
  logic                       cur_ok;
  logic [CNT_W:0]             cur_p1;
  logic                       nxt_ok;
  logic [TW-1:0]              tmo_diff;
  logic                       tmo_ok;
  logic                       iss_go;
  logic [TW-1:0]              nt;
  logic                       chk_win;
  logic                       scan_issue;
  logic                       scan_end;
  tdwt_pkg::cnt_t             cfg_cnt;
  logic                       cfg_init;
  logic                       do_init;
  tdwt_pkg::cnt_t             init_src;
  logic                       init_empty;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [TW-1:0]              ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [TW-1:0]              ram_rdata;

  tdwt_stamp_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (TW)
  ) u_stamps (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign acc         = req_i.valid && req_i.ready;
  assign now_in      = (req_i.now_time == T_ALL) ? T_CLAMP : req_i.now_time;
  assign id_ok       = (req_i.task_id != '0) && (req_i.task_id <= tcount_q);

  assign cur_ok   = (next_q != '0) && (next_q <= tcount_q);
  assign cur_p1   = {1'b0, next_q} + 1'b1;
  assign nxt_ok   = cur_p1 <= {1'b0, tcount_q};
  assign tmo_diff = now_q - cand_q;
  assign tmo_ok   = (now_q >= cand_q) && (DW'(tmo_diff) >= DW'(timeout_q));
  assign iss_go   = cur_ok && (!cleanup_q || tmo_ok);

  assign nt      = (op_q == tdwt_pkg::OP_DONE) ? T_ALL : now_q;
  assign chk_win = nt > ram_rdata;

  assign scan_issue = idx_q < tcount_q;
  assign scan_end   = !pend_q && !scan_issue;

  // task_count above the table size acts as the table size
  always_comb begin
    cfg_cnt = cfg_data_i[CNT_W-1:0];
    if (32'(cfg_cnt) > MAX_TASKS) begin
      cfg_cnt = CNT_W'(MAX_TASKS);
    end
  end

  assign cfg_init   = cfg_we_i && (cfg_idx_i == tdwt_pkg::REG_TASK_COUNT);
  assign do_init    = cfg_init || (acc && (req_i.operation == tdwt_pkg::OP_RESET));
  assign init_src   = cfg_init ? cfg_cnt : tcount_q;
  assign init_empty = (init_src == '0);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(idx_q);
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = AW'(idx_q);
    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_ISSUE: begin
        if (iss_go) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(next_q - 1'b1);
          ram_wdata = now_q;
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(id_q - 1'b1);
      end
      S_CHECK: begin
        if (chk_win) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(id_q - 1'b1);
          ram_wdata = nt;
        end
      end
      S_SCAN: begin
        ram_re = scan_issue;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      tcount_q      <= '0;
      timeout_q     <= '0;
      cleanup_q     <= 1'b1;
      next_q        <= '0;
      done_q        <= '0;
      left_q        <= '0;
      cand_q        <= T_ALL;
      last_q        <= '0;
      op_q          <= '0;
      id_q          <= '0;
      now_q         <= '0;
      granted_q     <= '0;
      status_q      <= 1'b0;
      idx_q         <= '0;
      open_q        <= '0;
      pend_q        <= 1'b0;
      post_q        <= 1'b0;
      setleft_q     <= 1'b0;
      rsp_valid_q   <= 1'b0;
      rsp_granted_q <= '0;
      rsp_status_q  <= 1'b0;
      rsp_next_q    <= '0;
      rsp_done_q    <= '0;
      rsp_left_q    <= '0;
      rsp_cand_q    <= '0;
      rsp_last_q    <= '0;
      rsp_cleanup_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_o.ready && (state_q != S_DONE)) begin
        rsp_valid_q <= 1'b0;
      end

      if (do_init) begin
        done_q    <= '0;
        left_q    <= '0;
        cleanup_q <= init_empty;
        next_q    <= init_empty ? '0 : CNT_W'(1);
        cand_q    <= init_empty ? T_ALL : '0;
        last_q    <= init_empty ? '0 : T_ALL;
      end

      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            op_q      <= req_i.operation;
            id_q      <= req_i.task_id;
            now_q     <= now_in;
            granted_q <= '0;
            status_q  <= 1'b0;
            case (req_i.operation) inside
              tdwt_pkg::OP_NEXT: begin
                state_q <= S_ISSUE;
              end
              tdwt_pkg::OP_RESET: begin
                idx_q  <= '0;
                post_q <= 1'b1;
                state_q <= (tcount_q == '0) ? S_ISSUE : S_CLEAR;
              end
              tdwt_pkg::OP_ALIVE, tdwt_pkg::OP_DONE: begin
                if (id_ok) begin
                  state_q <= S_READ;
                end else begin
                  status_q <= 1'b1;
                  state_q  <= S_DONE;
                end
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_CLEAR: begin
          idx_q <= idx_q + 1'b1;
          if (({1'b0, idx_q} + 1'b1) == {1'b0, tcount_q}) begin
            state_q <= post_q ? S_ISSUE : S_IDLE;
          end
        end
        S_ISSUE: begin
          if (!iss_go) begin
            state_q <= S_DONE;
          end else begin
            granted_q <= next_q;
            last_q    <= TW'(next_q);
            if (!cleanup_q && nxt_ok) begin
              next_q  <= cur_p1[CNT_W-1:0];
              cand_q  <= '0;
              state_q <= S_DONE;
            end else begin
              // last first-stage issue or a reissue: find the new oldest task
              setleft_q <= !cleanup_q;
              cand_q    <= T_ALL;
              next_q    <= '0;
              open_q    <= '0;
              idx_q     <= '0;
              pend_q    <= 1'b0;
              state_q   <= S_SCAN;
            end
          end
        end
        S_READ: begin
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (chk_win) begin
            granted_q <= id_q;
            if (op_q == tdwt_pkg::OP_DONE) begin
              done_q <= done_q + 1'b1;
            end
            if (cleanup_q && (next_q == id_q)) begin
              setleft_q <= 1'b0;
              cand_q    <= T_ALL;
              next_q    <= '0;
              open_q    <= '0;
              idx_q     <= '0;
              pend_q    <= 1'b0;
              state_q   <= S_SCAN;
            end else begin
              state_q <= S_DONE;
            end
          end else begin
            state_q <= S_DONE;
          end
        end
        S_SCAN: begin
          pend_q <= scan_issue;
          if (scan_issue) begin
            idx_q <= idx_q + 1'b1;
          end
          // with a read in flight, idx_q is the 1-based id of the word in ram_rdata
          if (pend_q) begin
            if (ram_rdata != T_ALL) begin
              open_q <= open_q + 1'b1;
            end
            if (ram_rdata < cand_q) begin
              cand_q <= ram_rdata;
              next_q <= idx_q;
            end
          end
          if (scan_end) begin
            if (setleft_q) begin
              left_q    <= open_q;
              cleanup_q <= 1'b1;
            end
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q   <= 1'b1;
            rsp_granted_q <= granted_q;
            rsp_status_q  <= status_q;
            rsp_next_q    <= next_q;
            rsp_done_q    <= done_q;
            rsp_left_q    <= left_q;
            rsp_cand_q    <= cand_q;
            rsp_last_q    <= last_q;
            rsp_cleanup_q <= cleanup_q;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tdwt_pkg::REG_TASK_COUNT: begin
            tcount_q <= cfg_cnt;
            idx_q    <= '0;
            post_q   <= 1'b0;
            state_q  <= (cfg_cnt == '0) ? S_IDLE : S_CLEAR;
          end
          tdwt_pkg::REG_TIMEOUT: begin
            timeout_q <= cfg_data_i[tdwt_pkg::TMO_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  assign rsp_o.valid                = rsp_valid_q;
  assign rsp_o.granted_task         = rsp_granted_q;
  assign rsp_o.status               = rsp_status_q;
  assign rsp_o.next_candidate       = rsp_next_q;
  assign rsp_o.completed_count      = rsp_done_q;
  assign rsp_o.remaining_at_cleanup = rsp_left_q;
  assign rsp_o.oldest_start         = rsp_cand_q;
  assign rsp_o.last_issued          = rsp_last_q;
  assign rsp_o.in_cleanup           = rsp_cleanup_q;

  a_next_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (next_q <= tcount_q))
    else $error("next pointer beyond task count");

  a_cand_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_IDLE) && (next_q != '0)) |-> (cand_q != T_ALL))
    else $error("candidate points at a completed task");

  a_rsp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the done step");

  a_cleanup_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(cleanup_q) |-> $past(do_init))
    else $error("left cleanup without a table init");

  a_bad_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && rsp_status_q) |-> (rsp_granted_q == '0))
    else $error("out-of-range id granted");

endmodule

FILE: bench/tdwt_grant_checker.sv
`timescale 1ns / 1ps
module tdwt_grant_checker
  import tdwt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tdwt_req_if         req_i,
  tdwt_rsp_if         rsp_i,
  input  logic        cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  localparam int unsigned NUM_SLOTS = 256;
  localparam logic [31:0] STAMP_DONE = '1;

  typedef struct packed {
    logic [CNT_W-1:0] granted;
    logic             status;
    logic [CNT_W-1:0] cand_task;
    logic [CNT_W-1:0] done_cnt;
    logic [CNT_W-1:0] left_cnt;
    logic [31:0]      cand_stamp;
    logic [31:0]      last_id;
    logic             cleanup;
  } grant_t;

  grant_t grant_q[$];
  int unsigned errs;

  // dispatcher state
  logic [31:0]  stamp_q[NUM_SLOTS];
  int unsigned  ntasks;
  logic [31:0]  tmo;
  bit           cleanup;
  int unsigned  nxt;
  logic [CNT_W-1:0] ndone;
  logic [CNT_W-1:0] nleft;
  logic [31:0]  cand;
  logic [31:0]  last;

  task automatic clear_table();
    for (int i = 0; i < NUM_SLOTS; i++) stamp_q[i] = '0;
    ndone = '0;
    nleft = '0;
    if (ntasks != 0) begin
      cleanup = 1'b0;
      nxt     = 1;
      cand    = '0;
      last    = STAMP_DONE;
    end else begin
      cleanup = 1'b1;
      nxt     = 0;
      cand    = STAMP_DONE;
      last    = '0;
    end
  endtask

  // oldest unfinished task, lowest index on ties
  task automatic find_oldest(output int unsigned open);
    open = 0;
    cand = STAMP_DONE;
    nxt  = 0;
    for (int i = 0; i < ntasks; i++) begin
      if (stamp_q[i] != STAMP_DONE) open++;
      if (stamp_q[i] < cand) begin
        cand = stamp_q[i];
        nxt  = i + 1;
      end
    end
  endtask

  task automatic dispatch(input logic [31:0] t, output int unsigned got);
    int unsigned cur;
    int unsigned open;
    cur = nxt;
    got = 0;
    if (cur == 0 || cur > ntasks) return;
    if (!cleanup) begin
      stamp_q[cur-1] = t;
      last = cur;
      nxt  = cur + 1;
      if (nxt <= ntasks) begin
        cand = '0;
      end else begin
        find_oldest(open);
        nleft   = open[CNT_W-1:0];
        cleanup = 1'b1;
      end
      got = cur;
      return;
    end
    // a clock that went backwards never reissues
    if (t < cand || t - cand < tmo) return;
    stamp_q[cur-1] = t;
    last = cur;
    find_oldest(open);
    got = cur;
  endtask

  task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    if (idx == REG_TASK_COUNT) begin
      ntasks = (data[CNT_W-1:0] > NUM_SLOTS) ? NUM_SLOTS : data[CNT_W-1:0];
      clear_table();
    end else begin
      tmo = data[31:0];
    end
  endtask

  task automatic predict(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] id,
                         input logic [31:0] t_in, output grant_t e);
    logic [31:0] t;
    logic [31:0] nt;
    int unsigned g;
    int unsigned open;
    t = (t_in == STAMP_DONE) ? STAMP_DONE - 1 : t_in;
    g = 0;
    e.status = 1'b0;
    case (op)
      OP_NEXT: dispatch(t, g);
      OP_RESET: begin
        clear_table();
        dispatch(t, g);
      end
      OP_ALIVE, OP_DONE: begin
        if (id < 1 || id > ntasks) begin
          e.status = 1'b1;
        end else begin
          nt = (op == OP_DONE) ? STAMP_DONE : t;
          // stale updates (stamp not raised) fail quietly
          if (nt > stamp_q[id-1]) begin
            stamp_q[id-1] = nt;
            g = 32'(id);
            if (cleanup && nxt == id) find_oldest(open);
            if (op == OP_DONE) ndone = ndone + 1'b1;
          end
        end
      end
      default: ;  // status and unused codes
    endcase
    e.granted    = g[CNT_W-1:0];
    e.cand_task  = nxt[CNT_W-1:0];
    e.done_cnt   = ndone;
    e.left_cnt   = nleft;
    e.cand_stamp = cand;
    e.last_id    = last;
    e.cleanup    = cleanup;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      errs++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
    end
  endtask

  task automatic compare(input grant_t e);
    check_field("granted_task", e.granted, rsp_i.granted_task);
    check_field("status", e.status, rsp_i.status);
    check_field("next_candidate", e.cand_task, rsp_i.next_candidate);
    check_field("completed_count", e.done_cnt, rsp_i.completed_count);
    check_field("remaining_at_cleanup", e.left_cnt, rsp_i.remaining_at_cleanup);
    check_field("oldest_start", e.cand_stamp, rsp_i.oldest_start);
    check_field("last_issued", e.last_id, rsp_i.last_issued);
    check_field("in_cleanup", e.cleanup, rsp_i.in_cleanup);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    grant_t exp_w;
    if (!rst_ni) begin
      ntasks = 0;
      tmo    = '0;
      clear_table();
      grant_q.delete();
      errs = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) apply_cfg(cfg_idx_i, cfg_data_i);
      if (req_i.valid && req_i.ready) begin
        predict(req_i.operation, req_i.task_id, req_i.now_time, exp_w);
        grant_q = {grant_q, exp_w};
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (grant_q.size() == 0) begin
          errs++;
          $display("%0t: result word with no expectation, granted_task %0h",
                   $time, rsp_i.granted_task);
        end else begin
          exp_w = grant_q.pop_front();
          compare(exp_w);
        end
      end
      mismatches_o <= errs;
      pending_o    <= grant_q.size();
    end
  end

endmodule

FILE: bench/tb_task_dispatcher_with_timeout_reissue.sv
`timescale 1ns / 1ps
module tb_task_dispatcher_with_timeout_reissue;
  import tdwt_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;
  int unsigned          mismatches;
  int unsigned          pending;

  tdwt_req_if #(.TW(32)) req_if ();
  tdwt_rsp_if #(.TW(32)) rsp_if ();

  task_dispatcher_with_timeout_reissue u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  tdwt_grant_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  int          gap_pct;
  int          stall_pct;
  int          stall_left;
  int unsigned cur_tasks;
  logic [31:0] tstamp;
  int unsigned idle_cycles;

  // sink side: ready drops in bursts of random length
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 9);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic put_word(input logic [OP_W-1:0] op, input logic [CNT_W-1:0] id,
                          input logic [31:0] t);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.task_id   <= id;
    req_if.now_time  <= t;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // hold the sender until every expected word is back
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input bit set_cnt, input logic [CNT_W-1:0] cnt,
                           input bit set_tmo, input logic [31:0] tmo);
    if (set_cnt) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= REG_TASK_COUNT;
      cfg_data <= CFG_W'(cnt);
      @(posedge clk_i);
      cur_tasks = cnt;
    end
    if (set_tmo) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= REG_TIMEOUT;
      cfg_data <= tmo;
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_word(input int next_pct, input int noise_pct, input int reset_pct);
    logic [OP_W-1:0]  op;
    logic [CNT_W-1:0] id;
    logic [31:0]      t;
    int               r;
    tstamp = tstamp + $urandom_range(0, 3);
    t  = tstamp;
    id = (cur_tasks == 0) ? CNT_W'($urandom_range(0, 2)) : CNT_W'($urandom_range(1, cur_tasks));
    r  = $urandom_range(0, 99);
    if (r < noise_pct) begin
      op = OP_W'($urandom_range(0, 7));
      id = CNT_W'($urandom_range(0, 511));
      case ($urandom_range(0, 3))
        0: t = $urandom();
        1: t = tstamp - $urandom_range(1, 60);
        2: t = '1;
        default: ;
      endcase
    end else begin
      r = $urandom_range(0, 99);
      if (r < next_pct) op = OP_NEXT;
      else if (r >= 100 - reset_pct) op = OP_RESET;
      else if (r < next_pct + (100 - next_pct) / 3) op = OP_ALIVE;
      else if (r < next_pct + 2 * (100 - next_pct) / 3) op = OP_DONE;
      else op = OP_STATUS;
    end
    put_word(op, id, t);
  endtask

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 20;
      default: return 50;
    endcase
  endfunction

  initial begin
    rst_ni           = 1'b0;
    gap_pct          = 0;
    stall_pct        = 0;
    cur_tasks        = 0;
    tstamp           = '0;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_STATUS;
    req_if.task_id   <= '0;
    req_if.now_time  <= '0;
    cfg_we           <= 1'b0;
    cfg_idx          <= REG_TASK_COUNT;
    cfg_data         <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // three tasks: first stage, cleanup, reissue and the odd cases
    write_cfg(1'b1, 9'd3, 1'b1, 32'd5);
    put_word(OP_STATUS, 9'd0, 32'd0);
    put_word(OP_DONE, 9'd3, 32'd10);       // done before ever issued
    put_word(OP_NEXT, 9'd0, 32'd10);
    put_word(OP_ALIVE, 9'd1, 32'd12);
    put_word(OP_NEXT, 9'd0, 32'd13);
    put_word(OP_NEXT, 9'd0, 32'd14);       // restamps task 3, enters cleanup
    put_word(OP_NEXT, 9'd0, 32'd15);       // timeout not reached
    put_word(OP_NEXT, 9'd0, 32'd40);
    put_word(OP_NEXT, 9'd0, 32'd1);        // clock went backwards
    put_word(OP_ALIVE, 9'd0, 32'd50);
    put_word(OP_DONE, 9'd4, 32'd50);
    put_word(OP_ALIVE, 9'd511, 32'hFFFF_FFFF);
    put_word(OP_ALIVE, 9'd2, 32'hFFFF_FFFF);
    put_word(OP_DONE, 9'd2, 32'd60);
    put_word(OP_DONE, 9'd2, 32'd61);       // already complete
    put_word(3'd5, 9'd1, 32'd62);
    put_word(3'd7, 9'd2, 32'd63);
    put_word(OP_RESET, 9'd0, 32'd70);
    settle();
    write_cfg(1'b1, 9'd0, 1'b1, 32'hFFFF_FFFF);
    put_word(OP_NEXT, 9'd0, 32'd5);
    put_word(OP_ALIVE, 9'd1, 32'd5);
    put_word(OP_RESET, 9'd0, 32'd6);
    settle();
    // every task finished in cleanup: nothing left to issue
    write_cfg(1'b1, 9'd2, 1'b1, 32'd0);
    put_word(OP_NEXT, 9'd0, 32'd1);
    put_word(OP_NEXT, 9'd0, 32'd2);
    put_word(OP_DONE, 9'd1, 32'd3);
    put_word(OP_DONE, 9'd2, 32'd3);
    put_word(OP_NEXT, 9'd0, 32'd100);

    for (int p = 0; p < 14; p++) begin
      logic [CNT_W-1:0] cnt;
      logic [31:0]      tmo;
      bit               set_cnt;
      int               n_items;
      cnt = $urandom_range(1, 12);
      tmo = $urandom_range(0, 30);
      set_cnt = ($urandom_range(0, 3) != 0);
      case (p)
        0: begin cnt = 9'd256; tmo = 32'd3; set_cnt = 1'b1; end
        1: begin cnt = 9'd0; tmo = $urandom(); set_cnt = 1'b1; end
        2: begin cnt = 9'd1; tmo = 32'd0; set_cnt = 1'b1; end
        3: begin cnt = 9'd2; tmo = 32'hFFFF_FFFF; set_cnt = 1'b1; end
        9: begin cnt = 9'd256; tmo = 32'd0; set_cnt = 1'b1; end
        default: ;
      endcase
      settle();
      gap_pct   = (p >= 12) ? 0 : pick_pct();
      stall_pct = (p >= 12) ? 0 : pick_pct();
      write_cfg(set_cnt, cnt, p < 4 || p == 9 || $urandom_range(0, 1) == 1, tmo);
      // now and then run the clock close to the top and through the wrap
      if ($urandom_range(0, 4) == 0) tstamp = 32'hFFFF_FF00;
      if (p == 0 || p == 9) begin
        for (int i = 0; i < 400; i++) random_word(80, 1, 0);
      end else begin
        n_items = 45 + $urandom_range(0, 10);
        for (int i = 0; i < n_items; i++) begin
          if ($urandom_range(0, 149) == 0) settle();
          random_word(45, 8, 2);
        end
      end
    end

    settle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
